>>> design/acs_pkg.sv
`timescale 1ns / 1ps

package acs_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned SUM_W    = 16;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned SEQ_SLOTS = 32;

  // Analog mux codes of the scan sequence; the low three bits select the channel
  localparam logic [7:0] CHAN_MASK = 8'h07;
  localparam logic [7:0] MUX_TABLE [SEQ_SLOTS] = '{
    8'h40, 8'h41, 8'h42, 8'h43, 8'h40, 8'h41, 8'h42, 8'h44,
    8'h40, 8'h41, 8'h42, 8'h45, 8'h40, 8'h41, 8'h42, 8'h46,
    8'h40, 8'h41, 8'h42, 8'h47, 8'h40, 8'h41, 8'h42, 8'h40,
    8'h40, 8'h41, 8'h42, 8'h41, 8'h40, 8'h41, 8'h42, 8'h42
  };

  typedef enum logic {
    ACT_CONVERT = 1'b0,
    ACT_COLLECT = 1'b1
  } action_e;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  typedef struct packed {
    logic               fresh;
    logic [CHAN_W-1:0]  next_channel;
    logic [CHAN_W-1:0]  channel_index;
    logic [SUM_W-1:0]   channel_sum;
    logic [COUNT_W-1:0] new_count;
    logic               last_result;
  } out_item_t;

endpackage

>>> design/acs_if.sv
`timescale 1ns / 1ps

// Input channel: conversion or collect transaction
interface acs_in_if;
  import acs_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [SAMPLE_W-1:0] sample;
  logic [COUNT_W-1:0] last_seen_count;

  modport source (output valid, output action, output sample, output last_seen_count,
                  input ready);
  modport sink   (input valid, input action, input sample, input last_seen_count,
                  output ready);
endinterface

// Output channel: one result transaction
interface acs_out_if;
  import acs_pkg::*;

  logic               valid;
  logic               ready;
  logic               fresh;
  logic [CHAN_W-1:0]  next_channel;
  logic [CHAN_W-1:0]  channel_index;
  logic [SUM_W-1:0]   channel_sum;
  logic [COUNT_W-1:0] new_count;
  logic               last_result;

  modport source (output valid, output fresh, output next_channel, output channel_index,
                  output channel_sum, output new_count, output last_result,
                  input ready);
  modport sink   (input valid, input fresh, input next_channel, input channel_index,
                  input channel_sum, input new_count, input last_result,
                  output ready);
endinterface

>>> design/acs_ram.sv
`timescale 1ns / 1ps

module acs_ram #(
  parameter int unsigned WIDTH  = 10,
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/adc_channel_sequencer_history_sum.sv
`timescale 1ns / 1ps

// ADC scan sequencer with a boxcar history per channel. A conversion transaction
// stores its sample in the history of the channel now selected (one RAM write),
// steps the scan sequence and returns the next channel in a result registered
// in the cycle after it is taken; a collect transaction whose count matches
// returns one stale result the same way. A fresh collect walks the history RAM
// one entry per cycle and returns one sum per channel, pausing after each channel
// while its sum waits for the output register. After reset the block clears the
// RAM, one entry per cycle, before it takes its first transaction.
// A finished result sits in an output register; the next transaction is taken
// in the cycle that result is accepted.
module adc_channel_sequencer_history_sum #(
  parameter int unsigned HISTORY_DEPTH   = 4,
  parameter int unsigned SEQUENCE_LENGTH = 20,
  parameter int unsigned CHANNEL_COUNT   = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  acs_in_if.sink    in_i,
  acs_out_if.source out_o
);
  import acs_pkg::*;

  localparam int unsigned NUM_ENTRIES = CHANNEL_COUNT * HISTORY_DEPTH;
  localparam int unsigned ADDR_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_ENTRIES - 1);
  localparam logic [PTR_W-1:0]  LAST_J    = PTR_W'(HISTORY_DEPTH - 1);
  localparam logic [CHAN_W-1:0] LAST_CH   = CHAN_W'(CHANNEL_COUNT - 1);

  // Channel of a sequence slot, reduced modulo the channel count
  function automatic logic [CHAN_W-1:0] chan_at(input logic [POS_W-1:0] pos);
    logic [CHAN_W:0] v;
    logic [7:0]      code;
    code = MUX_TABLE[pos] & CHAN_MASK;
    v    = {1'b0, code[CHAN_W-1:0]};
    for (int k = 0; k < 8; k++) begin
      if (v >= (CHAN_W+1)'(CHANNEL_COUNT)) begin
        v = v - (CHAN_W+1)'(CHANNEL_COUNT);
      end
    end
    return v[CHAN_W-1:0];
  endfunction

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [PTR_W-1:0]    j_q, j_d;
  logic [CHAN_W-1:0]   ch_q, ch_d;
  logic [SUM_W-1:0]    acc_q, acc_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic [PTR_W-1:0]    ptr_q [CHANNEL_COUNT];
  logic [PTR_W-1:0]    ptr_d [CHANNEL_COUNT];
  logic                out_vld_q, out_vld_d;
  out_item_t           out_q, out_d;

  logic                out_free;
  logic                in_acc;
  logic [CHAN_W-1:0]   cur_ch;
  logic [CH_W-1:0]     cur_idx;
  logic [PTR_W-1:0]    cur_ptr;
  logic [POS_W:0]      pos_inc;
  logic [POS_W-1:0]    pos_next;
  logic [CHAN_W-1:0]   nxt_ch;
  logic [CHAN_W-1:0]   now_ch;
  logic [ADDR_W-1:0]   conv_addr;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic [SAMPLE_W-1:0] ram_rdata;

  // Handshake
  assign out_free   = !out_vld_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_acc     = in_i.valid && in_i.ready;

  // Sequence stepping and write slot of the selected channel
  assign cur_ch    = chan_at(pos_q);
  assign cur_idx   = cur_ch[CH_W-1:0];
  assign cur_ptr   = ptr_q[cur_idx];
  assign pos_inc   = {1'b0, pos_q} + (POS_W+1)'(1);
  assign pos_next  = (pos_inc >= (POS_W+1)'(SEQUENCE_LENGTH)) ? '0 : pos_inc[POS_W-1:0];
  assign nxt_ch    = chan_at(pos_next);
  assign now_ch    = cur_ch;
  assign conv_addr = ADDR_W'(cur_ch) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(cur_ptr);

  // History RAM port
  assign ram_we    = (state_q == ST_CLEAR) ||
                     (in_acc && (in_i.action == ACT_CONVERT));
  assign ram_addr  = (state_q == ST_IDLE) ? conv_addr : addr_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : in_i.sample;

  acs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (NUM_ENTRIES)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Control
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    j_d       = j_q;
    ch_d      = ch_q;
    acc_d     = acc_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    out_vld_d = out_vld_q && !out_o.ready;
    out_d     = out_q;

    case (state_q)
      ST_CLEAR: begin
        addr_d = addr_q + ADDR_W'(1);
        if (addr_q == LAST_ADDR) begin
          addr_d  = '0;
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          out_vld_d           = 1'b1;
          out_d.fresh         = 1'b0;
          out_d.channel_index = '0;
          out_d.channel_sum   = '0;
          out_d.last_result   = 1'b1;
          out_d.next_channel  = now_ch;
          out_d.new_count     = cnt_q;
          if (in_i.action == ACT_CONVERT) begin
            // Ring slot replaces the oldest entry; the sum ignores order
            ptr_d[cur_idx]     = (cur_ptr == LAST_J) ? '0 : cur_ptr + PTR_W'(1);
            pos_d              = pos_next;
            out_d.next_channel = nxt_ch;
            if (nxt_ch == '0) begin
              cnt_d           = cnt_q + COUNT_W'(1);
              out_d.new_count = cnt_q + COUNT_W'(1);
            end
          end else if (in_i.last_seen_count != cnt_q) begin
            // Fresh collect: walk the RAM instead of answering now
            out_vld_d = 1'b0;
            addr_d    = '0;
            j_d       = '0;
            ch_d      = '0;
            acc_d     = '0;
            state_d   = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        // Read data of the previous address arrives this cycle
        if (j_q != '0) begin
          acc_d = acc_q + SUM_W'(ram_rdata);
        end
        addr_d = addr_q + ADDR_W'(1);
        if (j_q == LAST_J) begin
          state_d = ST_DRAIN;
        end else begin
          j_d = j_q + PTR_W'(1);
        end
      end

      ST_DRAIN: begin
        acc_d   = acc_q + SUM_W'(ram_rdata);
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_vld_d           = 1'b1;
          out_d.fresh         = 1'b1;
          out_d.next_channel  = now_ch;
          out_d.channel_index = ch_q;
          out_d.channel_sum   = acc_q;
          out_d.new_count     = cnt_q;
          out_d.last_result   = (ch_q == LAST_CH);
          if (ch_q == LAST_CH) begin
            state_d = ST_IDLE;
          end else begin
            ch_d    = ch_q + CHAN_W'(1);
            j_d     = '0;
            acc_d   = '0;
            state_d = ST_WALK;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      addr_q    <= '0;
      j_q       <= '0;
      ch_q      <= '0;
      pos_q     <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        ptr_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      j_q       <= j_d;
      ch_q      <= ch_d;
      pos_q     <= pos_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
      ptr_q     <= ptr_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    out_q <= out_d;
  end

  // Output channel
  assign out_o.valid         = out_vld_q;
  assign out_o.fresh         = out_q.fresh;
  assign out_o.next_channel  = out_q.next_channel;
  assign out_o.channel_index = out_q.channel_index;
  assign out_o.channel_sum   = out_q.channel_sum;
  assign out_o.new_count     = out_q.new_count;
  assign out_o.last_result   = out_q.last_result;

endmodule

>>> design/acs_checker.sv
`timescale 1ns / 1ps

module acs_checker #(
  parameter int unsigned CHANNEL_COUNT = 8
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        fresh_i,
  input logic [2:0]  next_channel_i,
  input logic [2:0]  channel_index_i,
  input logic [15:0] channel_sum_i,
  input logic [7:0]  new_count_i,
  input logic        last_result_i
);

  // A stalled result transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(fresh_i) &&
      $stable(channel_index_i) && $stable(channel_sum_i) && $stable(new_count_i) &&
      $stable(next_channel_i) && $stable(last_result_i))
    else $error("stalled result changed");

  // Conversion and stale results are single, empty results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !fresh_i |-> last_result_i && channel_index_i == 3'd0 &&
      channel_sum_i == 16'd0)
    else $error("non-fresh result malformed");

  // A fresh collect ends on the last channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && fresh_i && last_result_i |->
      channel_index_i == 3'(CHANNEL_COUNT - 1))
    else $error("fresh collect ended early");

  // No new transaction is taken while a collect is still delivering
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_result_i |-> !in_ready_i)
    else $error("input ready during collect");

endmodule

bind adc_channel_sequencer_history_sum acs_checker #(
  .CHANNEL_COUNT (CHANNEL_COUNT)
) u_acs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .fresh_i         (out_o.fresh),
  .next_channel_i  (out_o.next_channel),
  .channel_index_i (out_o.channel_index),
  .channel_sum_i   (out_o.channel_sum),
  .new_count_i     (out_o.new_count),
  .last_result_i   (out_o.last_result)
);

>>> tb/tb_adc_channel_sequencer_history_sum.sv
`timescale 1ns / 1ps

module tb_adc_channel_sequencer_history_sum;
  import acs_pkg::*;

  localparam int unsigned HIST_DEPTH   = 4;
  localparam int unsigned SEQ_LEN      = 20;
  localparam int unsigned NUM_CHAN     = 8;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned DRAIN_CYCLES = 80;

  logic clk_i = 1'b0;
  logic rst_ni;

  acs_in_if  in_if ();
  acs_out_if out_if ();

  adc_channel_sequencer_history_sum #(
    .HISTORY_DEPTH  (HIST_DEPTH),
    .SEQUENCE_LENGTH(SEQ_LEN),
    .CHANNEL_COUNT  (NUM_CHAN)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Scan model state, updated on every accepted input transaction
  logic [SAMPLE_W-1:0] hist_model [NUM_CHAN][HIST_DEPTH] = '{default: '0};
  logic [POS_W-1:0]    scan_pos = '0;
  logic [COUNT_W-1:0]  zero_count = '0;
  out_item_t           pending_results[$];

  int unsigned mismatch_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_request = 1'b0;
  bit          hold_taken = 1'b0;

  // Channel at a scan slot: groups of four, the fourth slot counts up from 3
  function automatic logic [CHAN_W-1:0] slot_channel(logic [POS_W-1:0] pos);
    int unsigned ch;
    if (pos[1:0] != 2'd3) begin
      ch = 32'(pos[1:0]);
    end else begin
      ch = 3 + 32'(pos[POS_W-1:2]);
    end
    return CHAN_W'((ch & 7) % NUM_CHAN);
  endfunction

  // Update the scan model and queue the results one transaction causes
  function automatic void model_transaction(logic act, logic [SAMPLE_W-1:0] smp,
                                            logic [COUNT_W-1:0] seen);
    out_item_t        res;
    int unsigned      ch;
    int unsigned      nxt;
    logic [SUM_W-1:0] total;
    res = '0;
    res.last_result = 1'b1;
    if (action_e'(act) == ACT_CONVERT) begin
      ch = 32'(slot_channel(scan_pos));
      for (int i = 0; i + 1 < HIST_DEPTH; i++) begin
        hist_model[ch][i] = hist_model[ch][i + 1];
      end
      hist_model[ch][HIST_DEPTH - 1] = smp;
      nxt = 32'(scan_pos) + 1;
      if (nxt >= SEQ_LEN) begin
        nxt = 0;
      end
      scan_pos = POS_W'(nxt);
      if (slot_channel(scan_pos) == '0) begin
        zero_count = zero_count + 1'b1;
      end
      res.next_channel = slot_channel(scan_pos);
      res.new_count    = zero_count;
      pending_results.push_back(res);
    end else if (seen == zero_count) begin
      // stale collect: nothing new since the caller looked
      res.next_channel = slot_channel(scan_pos);
      res.new_count    = zero_count;
      pending_results.push_back(res);
    end else begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        total = '0;
        for (int j = 0; j < HIST_DEPTH; j++) begin
          total = total + SUM_W'(hist_model[c][j]);
        end
        res.fresh         = 1'b1;
        res.next_channel  = slot_channel(scan_pos);
        res.channel_index = CHAN_W'(c);
        res.channel_sum   = total;
        res.new_count     = zero_count;
        res.last_result   = (c == NUM_CHAN - 1);
        pending_results.push_back(res);
      end
    end
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Check each result transaction, then predict from each input transaction
  always @(posedge clk_i) begin : result_check
    out_item_t exp_r;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual fresh=%0h ch=%0h sum=%0h",
                 $time, out_if.fresh, out_if.channel_index, out_if.channel_sum);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("fresh", 32'(exp_r.fresh), 32'(out_if.fresh));
        check_field("next_channel", 32'(exp_r.next_channel), 32'(out_if.next_channel));
        check_field("channel_index", 32'(exp_r.channel_index), 32'(out_if.channel_index));
        check_field("channel_sum", 32'(exp_r.channel_sum), 32'(out_if.channel_sum));
        check_field("new_count", 32'(exp_r.new_count), 32'(out_if.new_count));
        check_field("last_result", 32'(exp_r.last_result), 32'(out_if.last_result));
      end
    end
    if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
      model_transaction(in_if.action, in_if.sample, in_if.last_seen_count);
    end
  end

  // Result side ready: random stalls, or a long hold-off when requested
  always @(negedge clk_i) begin : result_ready
    if (hold_request && !hold_taken) begin
      hold_left  = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one transaction; last_seen_count is the live count XOR count_flip,
  // so a zero flip gives a stale collect
  task automatic send_item(action_e act, logic [SAMPLE_W-1:0] smp,
                           logic [COUNT_W-1:0] count_flip);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.action          <= act;
    in_if.sample          <= smp;
    in_if.last_seen_count <= zero_count ^ count_flip;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  task automatic test_after_reset();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_item(ACT_COLLECT, '0, 8'h00);
    send_item(ACT_COLLECT, '1, 8'hFF);
  endtask

  task automatic test_conversion_extremes();
    logic [SAMPLE_W-1:0] pattern [12] = '{
      10'h3FF, 10'h000, 10'h155, 10'h2AA, 10'h3FF, 10'h3FF,
      10'h001, 10'h200, 10'h3FF, 10'h3FE, 10'h000, 10'h3FF
    };
    tx_idle_pct = 21;
    rx_idle_pct = 62;
    foreach (pattern[i]) begin
      send_item(ACT_CONVERT, pattern[i], 8'h00);
    end
    send_item(ACT_COLLECT, '0, 8'h01);
    send_item(ACT_COLLECT, '0, 8'h00);
  endtask

  task automatic test_collect_cases();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_item(ACT_COLLECT, 10'h2AA, 8'h80);
    send_item(ACT_COLLECT, 10'h155, 8'h00);
    send_item(ACT_COLLECT, 10'h3FF, 8'hFF);
    send_item(ACT_CONVERT, 10'h3FF, 8'h00);
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_output_backpressure();
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_request = 1'b1;
    for (int i = 0; i < 9; i++) begin
      if (i % 3 == 0) begin
        send_item(ACT_COLLECT, SAMPLE_W'($urandom), COUNT_W'($urandom_range(1, 255)));
      end else begin
        send_item(ACT_CONVERT, SAMPLE_W'($urandom_range(1023)), 8'h00);
      end
    end
  endtask

  // Mostly conversions, with stale and fresh collects mixed in
  task automatic test_random_traffic(int unsigned n, int unsigned tx_pct,
                                     int unsigned rx_pct);
    int unsigned r;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 70) begin
        send_item(ACT_CONVERT, SAMPLE_W'($urandom_range(1023)), 8'h00);
      end else if (r < 82) begin
        send_item(ACT_COLLECT, SAMPLE_W'($urandom), 8'h00);
      end else begin
        send_item(ACT_COLLECT, SAMPLE_W'($urandom), COUNT_W'($urandom_range(255)));
      end
    end
  endtask

  initial begin : main_sequence
    in_if.valid           = 1'b0;
    in_if.action          = ACT_CONVERT;
    in_if.sample          = '0;
    in_if.last_seen_count = '0;
    rst_ni                = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_after_reset();
    test_conversion_extremes();
    test_collect_cases();
    test_output_backpressure();
    test_random_traffic(130, 21, 62);
    test_random_traffic(130, 62, 21);
    test_random_traffic(130, 0, 0);

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run
  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
